### sv/vhi_pkg.sv
// shared types, codes and constants of the versioned hash index
`timescale 1ns / 1ps

package vhi_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;

    localparam logic [63:0] FNV_OFFSET   = 64'hcbf29ce484222325;
    // fnv prime is 2^40 + 0x1b3
    localparam int          FNV_SHIFT    = 40;
    localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001b3;
    localparam logic [2:0]  HASH_LAST    = 3'd7;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE    = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_REV_REJECTED = 3'd4;
    localparam logic [2:0] ST_CONFLICT     = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] doc_key;
        logic [31:0] txn_id;
        logic [31:0] doc_handle;
        logic        revision_accepted;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_handle;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_INIT,
        S_PRD,
        S_PCHK,
        S_SRD,
        S_SCHK,
        S_SCLR,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW,
        WR_HANDLE,
        WR_STAMP,
        WR_FREE,
        WR_MOVE,
        WR_SWEEP
    } wr_op_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_HOME,
        IDX_NEXT,
        IDX_NEXT_RST
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        FND_HOLD,
        FND_ROW
    } fnd_op_t;

    typedef struct packed {
        logic       load_item;
        logic       hash_step;
        logic       mem_rd;
        wr_op_t     wr_op;
        idx_op_t    idx_op;
        logic       gap_ld;
        cnt_op_t    cnt_op;
        logic       st_ld;
        logic [2:0] st_code;
        fnd_op_t    fnd_op;
        logic       put_set;
        logic       resp_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic       hash_last;
        logic       full;
        logic       occ;
        logic       match;
        logic       cb_eq;
        logic       last_probe;
        logic       stays;
        logic       shift_end;
        logic       clear_last;
        logic       out_free;
        logic [1:0] cmd;
        logic       rev;
        logic       put;
    } dp_stat_t;

endpackage

### sv/vhi_datapath.sv
// table memory, hash unit, probe pointers and result register
`timescale 1ns / 1ps

module vhi_datapath #(
    parameter int TABLE_SLOTS = vhi_pkg::TABLE_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vhi_pkg::in_item_t in_item,
    input  vhi_pkg::dp_cmd_t  cmd,
    output vhi_pkg::dp_stat_t stat,
    input  logic              out_stall,
    output logic              out_valid,
    output vhi_pkg::out_item_t out_item
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = AW + 1;

    typedef struct packed {
        logic          occ;
        logic [63:0]   key;
        logic [31:0]   handle;
        logic [31:0]   cb;
        logic [31:0]   db;
        logic [AW-1:0] home;
    } row_t;

    row_t mem [TABLE_SLOTS];
    row_t rdata_reg;
    row_t mem_wdata;
    logic [AW-1:0] mem_waddr;
    logic          mem_we;

    vhi_pkg::in_item_t  item_reg;
    vhi_pkg::out_item_t out_item_reg;
    logic [63:0]   hash_reg, hash_next;
    logic [2:0]    hcnt_reg;
    logic [AW-1:0] home_reg, idx_reg, idx_next, gap_reg, clr_reg;
    logic [CW-1:0] n_reg, n_next, count_reg;
    logic [2:0]    st_reg;
    logic [31:0]   found_reg;
    logic          put_reg;
    logic          out_valid_reg;
    logic [7:0]    key_byte;
    logic [63:0]   hx;

    // one fnv-1a byte per cycle, prime split into a shift and a narrow product
    assign key_byte  = 8'(item_reg.doc_key >> {hcnt_reg, 3'b000});
    assign hx        = hash_reg ^ {56'd0, key_byte};
    assign hash_next = (hx << vhi_pkg::FNV_SHIFT) + hx * vhi_pkg::FNV_PRIME_LO;

    always_comb
    begin
        idx_next = idx_reg;
        n_next   = n_reg;
        case (cmd.idx_op)
            vhi_pkg::IDX_HOME:
            begin
                idx_next = hash_reg[AW-1:0];
                n_next   = '0;
            end
            vhi_pkg::IDX_NEXT:
            begin
                idx_next = idx_reg + 1'b1;
                n_next   = n_reg + 1'b1;
            end
            vhi_pkg::IDX_NEXT_RST:
            begin
                idx_next = idx_reg + 1'b1;
                n_next   = '0;
            end
            default:
            begin
                idx_next = idx_reg;
                n_next   = n_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b1;
        mem_waddr = idx_reg;
        mem_wdata = rdata_reg;
        case (cmd.wr_op)
            vhi_pkg::WR_NEW:
            begin
                mem_wdata.occ    = 1'b1;
                mem_wdata.key    = item_reg.doc_key;
                mem_wdata.handle = item_reg.doc_handle;
                mem_wdata.cb     = item_reg.txn_id;
                mem_wdata.db     = '0;
                mem_wdata.home   = home_reg;
            end
            vhi_pkg::WR_HANDLE: mem_wdata.handle = item_reg.doc_handle;
            vhi_pkg::WR_STAMP:  mem_wdata.db     = item_reg.txn_id;
            vhi_pkg::WR_FREE:   mem_wdata.occ    = 1'b0;
            vhi_pkg::WR_MOVE:   mem_waddr        = gap_reg;
            vhi_pkg::WR_SWEEP:
            begin
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.hash_step)
        begin
            hash_reg <= hash_next;
        end
        else if (cmd.load_item)
        begin
            hash_reg <= vhi_pkg::FNV_OFFSET;
        end
        if (cmd.idx_op == vhi_pkg::IDX_HOME)
        begin
            home_reg <= hash_reg[AW-1:0];
        end
        idx_reg <= idx_next;
        n_reg   <= n_next;
        if (cmd.gap_ld)
        begin
            gap_reg <= idx_reg;
        end
        if (cmd.st_ld)
        begin
            st_reg <= cmd.st_code;
        end
        if (cmd.load_item)
        begin
            found_reg <= '0;
        end
        else if (cmd.fnd_op == vhi_pkg::FND_ROW)
        begin
            found_reg <= rdata_reg.handle;
        end
        if (cmd.resp_ld)
        begin
            out_item_reg.status       <= st_reg;
            out_item_reg.found_handle <= found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            put_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                hcnt_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                hcnt_reg <= hcnt_reg + 1'b1;
            end
            case (cmd.cnt_op)
                vhi_pkg::CNT_INC: count_reg <= count_reg + 1'b1;
                vhi_pkg::CNT_DEC:
                begin
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default: count_reg <= count_reg;
            endcase
            if (cmd.wr_op == vhi_pkg::WR_SWEEP)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load_item)
            begin
                put_reg <= 1'b0;
            end
            else if (cmd.put_set)
            begin
                put_reg <= 1'b1;
            end
            if (cmd.resp_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.hash_last  = (hcnt_reg == vhi_pkg::HASH_LAST);
        stat.full       = (count_reg >= CW'(TABLE_SLOTS));
        stat.occ        = rdata_reg.occ;
        stat.match      = rdata_reg.occ && (rdata_reg.cb <= item_reg.txn_id)
                          && (rdata_reg.db < item_reg.txn_id)
                          && (rdata_reg.key == item_reg.doc_key);
        stat.cb_eq      = (rdata_reg.cb == item_reg.txn_id);
        stat.last_probe = (n_reg == CW'(TABLE_SLOTS - 1));
        // entry stays if its home lies cyclically in (gap, i]
        stat.stays      = (gap_reg < idx_reg)
                          ? ((gap_reg < rdata_reg.home) && (rdata_reg.home <= idx_reg))
                          : ((gap_reg < rdata_reg.home) || (rdata_reg.home <= idx_reg));
        stat.shift_end  = (n_reg == CW'(TABLE_SLOTS));
        stat.clear_last = &clr_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
        stat.cmd        = item_reg.cmd;
        stat.rev        = item_reg.revision_accepted;
        stat.put        = put_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### sv/vhi_ctrl.sv
// command sequencer of the versioned hash index
`timescale 1ns / 1ps

module vhi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vhi_pkg::dp_stat_t stat,
    output vhi_pkg::dp_cmd_t  cmd
);

    vhi_pkg::state_t state_reg, state_next;
    logic            ins_like;

    assign ins_like = (stat.cmd == vhi_pkg::CMD_INSERT) || stat.put;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vhi_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vhi_pkg::S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = vhi_pkg::S_IDLE;
                end
            end
            vhi_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vhi_pkg::S_HASH;
                end
            end
            vhi_pkg::S_HASH:
            begin
                if (stat.hash_last)
                begin
                    state_next = vhi_pkg::S_INIT;
                end
            end
            vhi_pkg::S_INIT:
            begin
                if (stat.cmd == vhi_pkg::CMD_INSERT && stat.full)
                begin
                    state_next = vhi_pkg::S_RESP;
                end
                else
                begin
                    state_next = vhi_pkg::S_PRD;
                end
            end
            vhi_pkg::S_PRD: state_next = vhi_pkg::S_PCHK;
            vhi_pkg::S_PCHK:
            begin
                state_next = vhi_pkg::S_RESP;
                if (stat.occ && !stat.match && !stat.last_probe)
                begin
                    state_next = vhi_pkg::S_PRD;
                end
                else if (stat.match && !ins_like && stat.rev)
                begin
                    if (stat.cmd == vhi_pkg::CMD_UPDATE && !stat.cb_eq && !stat.full)
                    begin
                        state_next = vhi_pkg::S_INIT;
                    end
                    else if (stat.cmd == vhi_pkg::CMD_DELETE && stat.cb_eq)
                    begin
                        state_next = vhi_pkg::S_SRD;
                    end
                end
            end
            vhi_pkg::S_SRD:
            begin
                state_next = stat.shift_end ? vhi_pkg::S_RESP : vhi_pkg::S_SCHK;
            end
            vhi_pkg::S_SCHK:
            begin
                if (!stat.occ)
                begin
                    state_next = vhi_pkg::S_RESP;
                end
                else if (stat.stays)
                begin
                    state_next = vhi_pkg::S_SRD;
                end
                else
                begin
                    state_next = vhi_pkg::S_SCLR;
                end
            end
            vhi_pkg::S_SCLR: state_next = vhi_pkg::S_SRD;
            vhi_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = vhi_pkg::S_IDLE;
                end
            end
            default: state_next = vhi_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.wr_op    = vhi_pkg::WR_NONE;
        cmd.idx_op   = vhi_pkg::IDX_HOLD;
        cmd.cnt_op   = vhi_pkg::CNT_HOLD;
        cmd.fnd_op   = vhi_pkg::FND_HOLD;
        cmd.st_code  = vhi_pkg::ST_OK;
        in_stall     = 1'b1;
        case (state_reg)
            vhi_pkg::S_CLEAR: cmd.wr_op = vhi_pkg::WR_SWEEP;
            vhi_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            vhi_pkg::S_HASH: cmd.hash_step = 1'b1;
            vhi_pkg::S_INIT:
            begin
                cmd.idx_op  = vhi_pkg::IDX_HOME;
                cmd.st_ld   = 1'b1;
                cmd.st_code = vhi_pkg::ST_FULL;
            end
            vhi_pkg::S_PRD: cmd.mem_rd = 1'b1;
            vhi_pkg::S_PCHK:
            begin
                cmd.st_ld = 1'b1;
                if (!stat.occ)
                begin
                    if (ins_like)
                    begin
                        cmd.wr_op   = vhi_pkg::WR_NEW;
                        cmd.cnt_op  = vhi_pkg::CNT_INC;
                        cmd.st_code = vhi_pkg::ST_OK;
                    end
                    else
                    begin
                        cmd.st_code = vhi_pkg::ST_NOT_FOUND;
                    end
                end
                else if (stat.match)
                begin
                    if (stat.cmd == vhi_pkg::CMD_INSERT)
                    begin
                        cmd.st_code = vhi_pkg::ST_DUPLICATE;
                        cmd.fnd_op  = vhi_pkg::FND_ROW;
                    end
                    else if (stat.put)
                    begin
                        // a second visible version behind the stamped one
                        cmd.st_code = vhi_pkg::ST_CONFLICT;
                    end
                    else
                    begin
                        cmd.fnd_op = vhi_pkg::FND_ROW;
                        if (stat.cmd == vhi_pkg::CMD_LOOKUP)
                        begin
                            cmd.st_code = vhi_pkg::ST_OK;
                        end
                        else if (!stat.rev)
                        begin
                            cmd.st_code = vhi_pkg::ST_REV_REJECTED;
                        end
                        else if (stat.cmd == vhi_pkg::CMD_UPDATE)
                        begin
                            if (stat.cb_eq)
                            begin
                                cmd.wr_op   = vhi_pkg::WR_HANDLE;
                                cmd.st_code = vhi_pkg::ST_OK;
                            end
                            else if (stat.full)
                            begin
                                cmd.st_code = vhi_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_op   = vhi_pkg::WR_STAMP;
                                cmd.put_set = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.st_code = vhi_pkg::ST_OK;
                            if (stat.cb_eq)
                            begin
                                cmd.wr_op  = vhi_pkg::WR_FREE;
                                cmd.cnt_op = vhi_pkg::CNT_DEC;
                                cmd.gap_ld = 1'b1;
                                cmd.idx_op = vhi_pkg::IDX_NEXT_RST;
                            end
                            else
                            begin
                                cmd.wr_op = vhi_pkg::WR_STAMP;
                            end
                        end
                    end
                end
                else if (stat.last_probe)
                begin
                    cmd.st_code = ins_like ? vhi_pkg::ST_FULL : vhi_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    cmd.st_ld  = 1'b0;
                    cmd.idx_op = vhi_pkg::IDX_NEXT;
                end
            end
            vhi_pkg::S_SRD: cmd.mem_rd = !stat.shift_end;
            vhi_pkg::S_SCHK:
            begin
                if (stat.occ)
                begin
                    if (stat.stays)
                    begin
                        cmd.idx_op = vhi_pkg::IDX_NEXT;
                    end
                    else
                    begin
                        cmd.wr_op = vhi_pkg::WR_MOVE;
                    end
                end
            end
            vhi_pkg::S_SCLR:
            begin
                cmd.wr_op  = vhi_pkg::WR_FREE;
                cmd.gap_ld = 1'b1;
                cmd.idx_op = vhi_pkg::IDX_NEXT;
            end
            vhi_pkg::S_RESP: cmd.resp_ld = stat.out_free;
            default: cmd.load_item = 1'b0;
        endcase
    end

endmodule

### sv/versioned_hash_index.sv
// Versioned hash index: open-addressed table of TABLE_SLOTS entries (a power of two) with
// linear probing and per-transaction visibility. After reset the block sweeps the table
// clear before it takes its first item. An item then passes through key hashing (one byte
// per cycle), a setup step, a read and a check of each slot probed through the
// single-port table memory, and a step that posts the result; an update that writes a new
// version probes a second time, and a delete in place adds a read and a check, with a move
// and a clear where needed, for each slot walked by the backward-shift repair. One item is
// worked at a time; the result register lets the next item enter while the previous result
// waits.
`timescale 1ns / 1ps

module versioned_hash_index #(
    parameter int TABLE_SLOTS = vhi_pkg::TABLE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  vhi_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output vhi_pkg::out_item_t out_item
);

    vhi_pkg::dp_cmd_t  cmd;
    vhi_pkg::dp_stat_t stat;

    vhi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    vhi_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
